FILE: hw/rtl/gcspg_pkg.sv
package gcspg_pkg;

  localparam int unsigned FrameW    = 13;  // frame size registers
  localparam int unsigned CoordW    = 12;  // pixel coordinates
  localparam int unsigned IdxW      = 6;   // pattern index
  localparam int unsigned PlaneCfgW = 4;   // requested plane count register
  localparam int unsigned GreyW     = 8;
  localparam int unsigned BitCntW   = 4;   // coordinate bit count, at most FrameW
  localparam int unsigned HalfW     = 5;   // pattern index over two, plus headroom
  localparam int unsigned LastW     = 7;   // 4 * planes + 1
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [GreyW-1:0] GreyWhite = 8'd255;
  localparam logic [GreyW-1:0] GreyBlack = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_COLUMNS = 2'd0,
    CFG_FRAME_ROWS    = 2'd1,
    CFG_BIT_PLANES    = 2'd2
  } cfg_reg_e;

  // values that follow from the configuration, kept in registers
  typedef struct packed {
    logic [FrameW-1:0]  cols;
    logic [FrameW-1:0]  rows;
    logic [BitCntW-1:0] vbits;
    logic [HalfW-1:0]   hbits_plus_p;
    logic [FrameW-1:0]  voff;
    logic [FrameW-1:0]  hoff;
    logic [LastW-1:0]   vert_end;  // 2 * planes + 2
    logic [LastW-1:0]   last_idx;  // 4 * planes + 1
  } derived_t;

  // least b >= 1 with 2^b >= size
  function automatic logic [BitCntW-1:0] bits_for(input logic [FrameW-1:0] size);
    logic [FrameW-1:0]  sm1;
    logic [BitCntW-1:0] b;
    sm1 = size - FrameW'(1);
    b   = BitCntW'(1);
    for (int i = 1; i < FrameW; i++) begin
      if (sm1[i]) b = BitCntW'(i + 1);
    end
    return b;
  endfunction

endpackage

FILE: hw/rtl/gray_code_stripe_pixel_generator_top.sv
// gray-code stripe pixel generator
//
// command channel: an item (pattern_index_i, pixel_row_i, pixel_column_i) is
// taken at each rising edge with start_i high and busy_o low. busy_o is
// always low, so one pixel can be presented every cycle
// result channel: done_o is high for exactly one cycle per item, with
// grey_level_o, index_error_o and last_pattern_o valid in that cycle; the
// receiver cannot stall, results simply stream out in item order
// pipeline: an item taken passes the input register, then one pass of logic
// into the result register, which drives done_o;
// throughput is one item per cycle, set by that single logic pass
// configuration: cfg_valid_i / cfg_ready_o write channel, cfg_ready_o is
// always high; index 0 frame columns, 1 frame rows, 2 requested bit planes,
// other indexes are dropped. the derived frame values are re-registered every
// cycle, so an item may follow a configuration transfer from the next cycle
// reset: clears the pipeline valid bits and loads the configuration defaults
// of 1024 x 768 with 4 planes
module gray_code_stripe_pixel_generator_top
  import gcspg_pkg::*;
#(
  parameter int unsigned MAX_BIT_PLANES = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [IdxW-1:0]       pattern_index_i,
  input  logic [CoordW-1:0]     pixel_row_i,
  input  logic [CoordW-1:0]     pixel_column_i,
  // result channel
  output logic                  done_o,
  output logic [GreyW-1:0]      grey_level_o,
  output logic                  index_error_o,
  output logic                  last_pattern_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [FrameW-1:0]     cfg_data_i
);

  localparam longint unsigned FrameTop = 64'd1 << CoordW;

  // configuration registers
  logic [FrameW-1:0]    frame_columns_q;
  logic [FrameW-1:0]    frame_rows_q;
  logic [PlaneCfgW-1:0] bit_planes_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_columns_q <= FrameW'(1024);
      frame_rows_q    <= FrameW'(768);
      bit_planes_q    <= PlaneCfgW'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_COLUMNS: frame_columns_q <= cfg_data_i;
        CFG_FRAME_ROWS:    frame_rows_q    <= cfg_data_i;
        CFG_BIT_PLANES:    bit_planes_q    <= cfg_data_i[PlaneCfgW-1:0];
        default: ;  // unused index, transfer is dropped
      endcase
    end
  end

  // frame size clamp: zero reads as one, oversize saturates to the coordinate range
  function automatic logic [FrameW-1:0] clamp_frame(input logic [FrameW-1:0] v);
    logic [FrameW-1:0] r;
    if (v == '0) r = FrameW'(1);
    else if (64'(v) > FrameTop) r = FrameW'(FrameTop);
    else r = v;
    return r;
  endfunction

  derived_t derived_d, derived_q;

  always_comb begin
    logic [FrameW-1:0]  cols, rows;
    logic [BitCntW-1:0] vb, hb, req, p;
    logic [FrameW:0]    vspan, hspan;
    cols = clamp_frame(frame_columns_q);
    rows = clamp_frame(frame_rows_q);
    vb   = bits_for(cols);
    hb   = bits_for(rows);
    // slack to the next power of two, halved to center the stripes
    vspan = (FrameW+1)'(1) << vb;
    hspan = (FrameW+1)'(1) << hb;
    vspan = vspan - {1'b0, cols};
    hspan = hspan - {1'b0, rows};
    // plane count: requested value clamped, then limited by both bit counts
    req = bit_planes_q;
    if (req == '0) req = BitCntW'(1);
    if (32'(req) > MAX_BIT_PLANES) req = BitCntW'(MAX_BIT_PLANES);
    p = (vb < hb) ? vb : hb;
    if (req < p) p = req;
    derived_d.cols         = cols;
    derived_d.rows         = rows;
    derived_d.vbits        = vb;
    derived_d.hbits_plus_p = HalfW'(hb) + HalfW'(p);
    derived_d.voff         = vspan[FrameW:1];
    derived_d.hoff         = hspan[FrameW:1];
    derived_d.vert_end     = (LastW'(p) << 1) + LastW'(2);
    derived_d.last_idx     = (LastW'(p) << 2) + LastW'(1);
  end

  always_ff @(posedge clk_i) begin
    derived_q <= derived_d;
  end

  // input register
  logic              in_valid_q;
  logic [IdxW-1:0]   idx_q;
  logic [CoordW-1:0] row_q, col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      idx_q <= pattern_index_i;
      row_q <= pixel_row_i;
      col_q <= pixel_column_i;
    end
  end

  // pixel evaluation
  logic [GreyW-1:0] grey_d;
  logic             err_d, last_d;

  always_comb begin
    logic [FrameW-1:0] vsum, hsum, vgray, hgray;
    logic [HalfW-1:0]  half, vsel, hsel;
    logic              odd, lit;
    vsum  = FrameW'(col_q) + derived_q.voff;
    hsum  = FrameW'(row_q) + derived_q.hoff;
    vgray = vsum ^ (vsum >> 1);
    hgray = hsum ^ (hsum >> 1);
    half  = HalfW'(idx_q >> 1);
    odd   = idx_q[0];
    // bit planes run msb first
    vsel  = HalfW'(derived_q.vbits) - half;
    hsel  = derived_q.hbits_plus_p - half;
    err_d  = (LastW'(idx_q) > derived_q.last_idx)
          || (FrameW'(row_q) >= derived_q.rows)
          || (FrameW'(col_q) >= derived_q.cols);
    last_d = (LastW'(idx_q) == derived_q.last_idx);
    if (LastW'(idx_q) < derived_q.vert_end) lit = vgray[vsel[BitCntW-1:0]];
    else lit = hgray[hsel[BitCntW-1:0]];
    // white / black full frames come first
    if (idx_q < IdxW'(2)) lit = 1'b1;
    if (err_d) grey_d = GreyBlack;
    else grey_d = (lit != odd) ? GreyWhite : GreyBlack;
  end

  // result register
  logic             done_q;
  logic [GreyW-1:0] grey_q;
  logic             err_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      grey_q <= grey_d;
      err_q  <= err_d;
      last_q <= last_d;
    end
  end

  assign done_o         = done_q;
  assign grey_level_o   = grey_q;
  assign index_error_o  = err_q;
  assign last_pattern_o = last_q;

endmodule

FILE: hw/rtl/gcspg_checker.sv
module gcspg_checker
  import gcspg_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [GreyW-1:0]   grey_level_o,
  input logic               index_error_o,
  input logic               last_pattern_o
);

  // every transfer in gives one result, through the input and result registers
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("result missing two cycles after command transfer");

  // no result without a matching command transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without command transfer");

  // error results are black
  a_err_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && index_error_o) |-> (grey_level_o == GreyBlack))
    else $error("error result with nonzero grey level");

  // grey level is binary
  a_grey_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (grey_level_o == GreyBlack || grey_level_o == GreyWhite))
    else $error("grey level neither black nor white");

endmodule

bind gray_code_stripe_pixel_generator_top gcspg_checker u_gcspg_checker (.*);
